// ----- rtl/vat_pkg.sv -----
// ----------------------------------------------------------------------------
// vat_pkg: shared types, constants and functions for the vertex transform
// Mode and register codes, pipeline enables, and the sine table generator
// used to build the quarter-wave trig table at elaboration.
// ----------------------------------------------------------------------------
package vat_pkg;

	// default widths
	localparam int COORD_BITS_DEF     = 16;
	localparam int TRIG_FRAC_BITS_DEF = 16;

	localparam int MODE_BITS    = 3;
	localparam int ANGLE_BITS   = 9;
	localparam int CFG_IDX_BITS = 2;

	// quarter-wave table: entries for 0..90 degrees
	localparam int ROM_DEPTH    = 91;
	localparam int ROM_IDX_BITS = 7;

	localparam logic [ANGLE_BITS-1:0] DEG_QUARTER = ANGLE_BITS'(90);
	localparam logic [ANGLE_BITS-1:0] DEG_HALF    = ANGLE_BITS'(180);
	localparam logic [ANGLE_BITS-1:0] DEG_THREE_Q = ANGLE_BITS'(270);
	localparam logic [ANGLE_BITS-1:0] DEG_FULL    = ANGLE_BITS'(360);

	// pi in Q60 and one degree in Q60
	localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
	localparam logic [63:0] DEG_Q60 = PI_Q60 / 64'd180;

	// Taylor divisors (2n)(2n+1) for n = 1..8
	localparam logic [63:0] TAYLOR_DIV [1:8] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
	};

	// transform select codes
	typedef enum logic [MODE_BITS-1:0] {
		MODE_TRANSLATE = 3'd0,
		MODE_SCALE     = 3'd1,
		MODE_ROTATE    = 3'd2,
		MODE_SHEAR     = 3'd3,
		MODE_REFLECT   = 3'd4
	} mode_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MODE     = 2'd0,
		REG_AMOUNT_X = 2'd1,
		REG_AMOUNT_Y = 2'd2,
		REG_ANGLE    = 2'd3
	} cfg_reg_t;

	// load enables of the three pipeline registers
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

	// table index and sign for one angle
	typedef struct packed {
		logic [ROM_IDX_BITS-1:0] idx;
		logic                    neg;
	} trig_sel_t;

	// sin(k degrees): Q30 Taylor series rounded half up to frac fraction bits
	function automatic logic [31:0] sin_rom_entry(input int unsigned k,
		input int unsigned frac);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		longint      sum;
		x    = (DEG_Q60 * 64'(k) + (64'd1 << 29)) >> 30;
		x2   = (x * x + (64'd1 << 29)) >> 30;
		term = x;
		sum  = longint'(x);
		for (int n = 1; n <= 8; n++) begin
			term = ((term * x2) >> 30) / TAYLOR_DIV[n];
			if ((n % 2) == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		return 32'((64'(sum) + (64'd1 << (29 - frac))) >> (30 - frac));
	endfunction

	// fold an angle below 360 onto the quarter-wave table
	function automatic trig_sel_t trig_fold(input logic [ANGLE_BITS-1:0] a);
		trig_sel_t r;
		if (a <= DEG_QUARTER) begin
			r.idx = ROM_IDX_BITS'(a);
			r.neg = 1'b0;
		end else if (a <= DEG_HALF) begin
			r.idx = ROM_IDX_BITS'(DEG_HALF - a);
			r.neg = 1'b0;
		end else if (a <= DEG_THREE_Q) begin
			r.idx = ROM_IDX_BITS'(a - DEG_HALF);
			r.neg = 1'b1;
		end else begin
			r.idx = ROM_IDX_BITS'(DEG_FULL - a);
			r.neg = 1'b1;
		end
		return r;
	endfunction

endpackage

// ----- rtl/vertex_affine_transform.sv -----
// ----------------------------------------------------------------------------
// vertex_affine_transform: 2D affine transform of polygon vertices
// Translate, scale, rotate, shear or reflect one vertex per transaction with
// saturation to the coordinate width.
// ----------------------------------------------------------------------------
// Usage:
// - Program mode, amount_x, amount_y and angle_deg through the write port
//   (cfg_we, cfg_index, cfg_wdata) while no vertex is in flight. An angle
//   write looks up sine and cosine at once; the new setting applies to the
//   next vertex accepted after the write.
// - Vertices enter on in_valid/in_ready; results leave on out_valid/out_ready
//   with is_last copied to last_out and clipped set on saturation.
// - An accepted input transaction passes through the input register, product
//   register and result register in that order before out_valid rises.
// - Throughput: one vertex per cycle while out_ready stays high; the three
//   registers form a pipeline whose rate is set by the single multiply stage.
// - When the receiver stalls, the result register holds its transaction and
//   earlier stages keep filling until all three are occupied, then in_ready
//   drops. No transaction is dropped or duplicated.
// - Reset clears the registers to translate with zero amounts and zero angle
//   and empties the pipeline.
// ----------------------------------------------------------------------------
module vertex_affine_transform
	import vat_pkg::*;
#(
	parameter int COORD_BITS     = COORD_BITS_DEF,
	parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
	parameter int CFG_W          = (COORD_BITS > ANGLE_BITS) ? COORD_BITS : ANGLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [CFG_W-1:0]              cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_BITS-1:0]  coord_x,
	input  logic signed [COORD_BITS-1:0]  coord_y,
	input  logic                          is_last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_BITS-1:0]  new_x,
	output logic signed [COORD_BITS-1:0]  new_y,
	output logic                          last_out,
	output logic                          clipped
);

	localparam int SW  = TRIG_FRAC_BITS + 2;
	localparam int OPW = (COORD_BITS > SW) ? COORD_BITS : SW;
	localparam int PW  = COORD_BITS + OPW;

	logic [MODE_BITS-1:0]         mode;
	logic signed [COORD_BITS-1:0] amount_x, amount_y;
	logic signed [SW-1:0]         sin_val, cos_val;
	logic signed [COORD_BITS-1:0] x_s2, y_s2;
	logic                         last_s2;
	logic signed [PW-1:0]         pa_s2, pb_s2, pc_s2, pd_s2;
	logic                         valid_s1, valid_s2, valid_s3;
	logic                         rdy1, rdy2, rdy3;
	stage_en_t                    en;

	// pipeline flow control: a stage loads when it is empty or moving on
	always_comb begin
		rdy3  = !valid_s3 || out_ready;
		rdy2  = !valid_s2 || rdy3;
		rdy1  = !valid_s1 || rdy2;
		en.s1 = in_valid && rdy1;
		en.s2 = valid_s1 && rdy2;
		en.s3 = valid_s2 && rdy3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
		end
	end

	assign in_ready  = rdy1;
	assign out_valid = valid_s3;

	// configuration registers and trig lookup
	vat_cfg_regs #(
		.COORD_BITS     (COORD_BITS),
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS),
		.CFG_W          (CFG_W),
		.SW             (SW)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.mode      (mode),
		.amount_x  (amount_x),
		.amount_y  (amount_y),
		.sin_val   (sin_val),
		.cos_val   (cos_val)
	);

	// input register and products
	vat_mult_stage #(
		.COORD_BITS     (COORD_BITS),
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS),
		.SW             (SW),
		.OPW            (OPW),
		.PW             (PW)
	) u_mult (
		.clk      (clk),
		.en       (en),
		.mode     (mode),
		.amount_x (amount_x),
		.amount_y (amount_y),
		.sin_val  (sin_val),
		.cos_val  (cos_val),
		.coord_x  (coord_x),
		.coord_y  (coord_y),
		.is_last  (is_last),
		.x_s2     (x_s2),
		.y_s2     (y_s2),
		.last_s2  (last_s2),
		.pa_s2    (pa_s2),
		.pb_s2    (pb_s2),
		.pc_s2    (pc_s2),
		.pd_s2    (pd_s2)
	);

	// combine, saturate and result register
	vat_sum_stage #(
		.COORD_BITS     (COORD_BITS),
		.TRIG_FRAC_BITS (TRIG_FRAC_BITS),
		.PW             (PW)
	) u_sum (
		.clk      (clk),
		.en       (en),
		.mode     (mode),
		.amount_x (amount_x),
		.amount_y (amount_y),
		.x_s2     (x_s2),
		.y_s2     (y_s2),
		.last_s2  (last_s2),
		.pa_s2    (pa_s2),
		.pb_s2    (pb_s2),
		.pc_s2    (pc_s2),
		.pd_s2    (pd_s2),
		.new_x    (new_x),
		.new_y    (new_y),
		.last_out (last_out),
		.clipped  (clipped)
	);

endmodule

// ----- rtl/vat_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// vat_cfg_regs: configuration registers
// Holds mode and amounts, and on an angle write looks up sine and cosine in
// the quarter-wave table so the datapath sees ready-made coefficients.
// ----------------------------------------------------------------------------
module vat_cfg_regs
	import vat_pkg::*;
#(
	parameter int COORD_BITS     = COORD_BITS_DEF,
	parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
	parameter int CFG_W          = (COORD_BITS > ANGLE_BITS) ? COORD_BITS : ANGLE_BITS,
	parameter int SW             = TRIG_FRAC_BITS + 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  logic [CFG_W-1:0]              cfg_wdata,
	output logic [MODE_BITS-1:0]          mode,
	output logic signed [COORD_BITS-1:0]  amount_x,
	output logic signed [COORD_BITS-1:0]  amount_y,
	output logic signed [SW-1:0]          sin_val,
	output logic signed [SW-1:0]          cos_val
);

	localparam int TW = TRIG_FRAC_BITS + 1;
	localparam logic [TW-1:0] COS_ZERO = TW'(sin_rom_entry(90, TRIG_FRAC_BITS));

	logic [TW-1:0]           rom [ROM_DEPTH];
	logic [MODE_BITS-1:0]    mode_q;
	logic [COORD_BITS-1:0]   amount_x_q;
	logic [COORD_BITS-1:0]   amount_y_q;
	logic [SW-1:0]           sin_q;
	logic [SW-1:0]           cos_q;
	logic [ANGLE_BITS-1:0]   ang_raw;
	logic [ANGLE_BITS-1:0]   ang_red;
	logic [ANGLE_BITS-1:0]   ang_cos_raw;
	logic [ANGLE_BITS-1:0]   ang_cos;
	trig_sel_t               sel_sin;
	trig_sel_t               sel_cos;
	logic [SW-1:0]           mag_sin;
	logic [SW-1:0]           mag_cos;
	logic [SW-1:0]           sin_next;
	logic [SW-1:0]           cos_next;

	// constant quarter-wave sine table
	for (genvar k = 0; k < ROM_DEPTH; k++) begin : g_rom
		assign rom[k] = TW'(sin_rom_entry(k, TRIG_FRAC_BITS));
	end

	// reduce the written angle and fold both lookups
	always_comb begin
		ang_raw     = cfg_wdata[ANGLE_BITS-1:0];
		ang_red     = (ang_raw >= DEG_FULL) ? ang_raw - DEG_FULL : ang_raw;
		ang_cos_raw = ang_red + DEG_QUARTER;
		ang_cos     = (ang_cos_raw >= DEG_FULL) ? ang_cos_raw - DEG_FULL : ang_cos_raw;
		sel_sin     = trig_fold(ang_red);
		sel_cos     = trig_fold(ang_cos);
		mag_sin     = {1'b0, rom[sel_sin.idx]};
		mag_cos     = {1'b0, rom[sel_cos.idx]};
		sin_next    = sel_sin.neg ? -mag_sin : mag_sin;
		cos_next    = sel_cos.neg ? -mag_cos : mag_cos;
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= '0;
			amount_x_q <= '0;
			amount_y_q <= '0;
			sin_q      <= '0;
			cos_q      <= {1'b0, COS_ZERO};
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:     mode_q     <= cfg_wdata[MODE_BITS-1:0];
				REG_AMOUNT_X: amount_x_q <= cfg_wdata[COORD_BITS-1:0];
				REG_AMOUNT_Y: amount_y_q <= cfg_wdata[COORD_BITS-1:0];
				REG_ANGLE: begin
					sin_q <= sin_next;
					cos_q <= cos_next;
				end
				default: ;
			endcase
		end
	end

	assign mode     = mode_q;
	assign amount_x = amount_x_q;
	assign amount_y = amount_y_q;
	assign sin_val  = sin_q;
	assign cos_val  = cos_q;

endmodule

// ----- rtl/vat_mult_stage.sv -----
// ----------------------------------------------------------------------------
// vat_mult_stage: input register and product stage
// Captures the vertex, picks multiplier operands by mode and registers the
// four products for the combine stage.
// ----------------------------------------------------------------------------
module vat_mult_stage
	import vat_pkg::*;
#(
	parameter int COORD_BITS     = COORD_BITS_DEF,
	parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
	parameter int SW             = TRIG_FRAC_BITS + 2,
	parameter int OPW            = (COORD_BITS > SW) ? COORD_BITS : SW,
	parameter int PW             = COORD_BITS + OPW
) (
	input  logic                          clk,
	input  stage_en_t                     en,
	input  logic [MODE_BITS-1:0]          mode,
	input  logic signed [COORD_BITS-1:0]  amount_x,
	input  logic signed [COORD_BITS-1:0]  amount_y,
	input  logic signed [SW-1:0]          sin_val,
	input  logic signed [SW-1:0]          cos_val,
	input  logic signed [COORD_BITS-1:0]  coord_x,
	input  logic signed [COORD_BITS-1:0]  coord_y,
	input  logic                          is_last,
	output logic signed [COORD_BITS-1:0]  x_s2,
	output logic signed [COORD_BITS-1:0]  y_s2,
	output logic                          last_s2,
	output logic signed [PW-1:0]          pa_s2,
	output logic signed [PW-1:0]          pb_s2,
	output logic signed [PW-1:0]          pc_s2,
	output logic signed [PW-1:0]          pd_s2
);

	logic signed [COORD_BITS-1:0] x_s1;
	logic signed [COORD_BITS-1:0] y_s1;
	logic                         last_s1;
	logic signed [COORD_BITS-1:0] a0, a1, a2, a3;
	logic signed [OPW-1:0]        b0, b1, b2, b3;
	logic signed [OPW-1:0]        ax_ext, ay_ext, sin_ext, cos_ext;

	// input register
	always_ff @(posedge clk) begin
		if (en.s1) begin
			x_s1    <= coord_x;
			y_s1    <= coord_y;
			last_s1 <= is_last;
		end
	end

	// operand select
	always_comb begin
		ax_ext  = OPW'(amount_x);
		ay_ext  = OPW'(amount_y);
		sin_ext = OPW'(sin_val);
		cos_ext = OPW'(cos_val);
		a0 = x_s1;
		a1 = y_s1;
		a2 = x_s1;
		a3 = y_s1;
		b0 = '0;
		b1 = '0;
		b2 = '0;
		b3 = '0;
		case (mode)
			MODE_SCALE: begin
				b0 = ax_ext;
				b1 = ay_ext;
			end
			MODE_ROTATE: begin
				b0 = cos_ext;
				b1 = sin_ext;
				b2 = sin_ext;
				b3 = cos_ext;
			end
			MODE_SHEAR: begin
				a0 = y_s1;
				b0 = ax_ext;
				a1 = x_s1;
				b1 = ay_ext;
			end
			default: ;
		endcase
	end

	// product register
	always_ff @(posedge clk) begin
		if (en.s2) begin
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			last_s2 <= last_s1;
			pa_s2   <= PW'(a0) * PW'(b0);
			pb_s2   <= PW'(a1) * PW'(b1);
			pc_s2   <= PW'(a2) * PW'(b2);
			pd_s2   <= PW'(a3) * PW'(b3);
		end
	end

endmodule

// ----- rtl/vat_sum_stage.sv -----
// ----------------------------------------------------------------------------
// vat_sum_stage: combine, saturate and result register
// Forms the transformed vertex from the products by mode, truncates rotate
// results toward zero, saturates to the coordinate width and flags clipping.
// ----------------------------------------------------------------------------
module vat_sum_stage
	import vat_pkg::*;
#(
	parameter int COORD_BITS     = COORD_BITS_DEF,
	parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
	parameter int PW             = 2 * COORD_BITS
) (
	input  logic                          clk,
	input  stage_en_t                     en,
	input  logic [MODE_BITS-1:0]          mode,
	input  logic signed [COORD_BITS-1:0]  amount_x,
	input  logic signed [COORD_BITS-1:0]  amount_y,
	input  logic signed [COORD_BITS-1:0]  x_s2,
	input  logic signed [COORD_BITS-1:0]  y_s2,
	input  logic                          last_s2,
	input  logic signed [PW-1:0]          pa_s2,
	input  logic signed [PW-1:0]          pb_s2,
	input  logic signed [PW-1:0]          pc_s2,
	input  logic signed [PW-1:0]          pd_s2,
	output logic signed [COORD_BITS-1:0]  new_x,
	output logic signed [COORD_BITS-1:0]  new_y,
	output logic                          last_out,
	output logic                          clipped
);

	localparam int SUMW = PW + 1;
	localparam logic signed [SUMW-1:0] SAT_HI =
		{{(SUMW - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
	localparam logic signed [SUMW-1:0] SAT_LO = ~SAT_HI;
	localparam logic signed [SUMW-1:0] TRUNC_BIAS =
		{{(SUMW - TRIG_FRAC_BITS){1'b0}}, {TRIG_FRAC_BITS{1'b1}}};

	logic signed [SUMW-1:0]       xe, ye, pa, pb, pc, pd;
	logic signed [SUMW-1:0]       rot_x, rot_y, rot_x_adj, rot_y_adj;
	logic signed [SUMW-1:0]       nx, ny;
	logic signed [COORD_BITS-1:0] sat_x, sat_y;
	logic                         hit_x, hit_y;
	logic signed [COORD_BITS-1:0] new_x_s3, new_y_s3;
	logic                         last_s3, clipped_s3;

	// combine by mode
	always_comb begin
		xe = SUMW'(x_s2);
		ye = SUMW'(y_s2);
		pa = SUMW'(pa_s2);
		pb = SUMW'(pb_s2);
		pc = SUMW'(pc_s2);
		pd = SUMW'(pd_s2);
		// rotate: arithmetic shift with bias gives truncation toward zero
		rot_x     = pa - pb;
		rot_y     = pc + pd;
		rot_x_adj = rot_x[SUMW-1] ? rot_x + TRUNC_BIAS : rot_x;
		rot_y_adj = rot_y[SUMW-1] ? rot_y + TRUNC_BIAS : rot_y;
		nx = xe;
		ny = ye;
		case (mode)
			MODE_TRANSLATE: begin
				nx = xe + SUMW'(amount_x);
				ny = ye + SUMW'(amount_y);
			end
			MODE_SCALE: begin
				nx = pa;
				ny = pb;
			end
			MODE_ROTATE: begin
				nx = rot_x_adj >>> TRIG_FRAC_BITS;
				ny = rot_y_adj >>> TRIG_FRAC_BITS;
			end
			MODE_SHEAR: begin
				nx = xe + pa;
				ny = ye + pb;
			end
			MODE_REFLECT: begin
				nx = -ye;
				ny = -xe;
			end
			default: ;
		endcase
	end

	// saturate to the coordinate range
	always_comb begin
		hit_x = 1'b0;
		hit_y = 1'b0;
		sat_x = nx[COORD_BITS-1:0];
		sat_y = ny[COORD_BITS-1:0];
		if (nx > SAT_HI) begin
			sat_x = SAT_HI[COORD_BITS-1:0];
			hit_x = 1'b1;
		end else if (nx < SAT_LO) begin
			sat_x = SAT_LO[COORD_BITS-1:0];
			hit_x = 1'b1;
		end
		if (ny > SAT_HI) begin
			sat_y = SAT_HI[COORD_BITS-1:0];
			hit_y = 1'b1;
		end else if (ny < SAT_LO) begin
			sat_y = SAT_LO[COORD_BITS-1:0];
			hit_y = 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (en.s3) begin
			new_x_s3   <= sat_x;
			new_y_s3   <= sat_y;
			last_s3    <= last_s2;
			clipped_s3 <= hit_x | hit_y;
		end
	end

	assign new_x    = new_x_s3;
	assign new_y    = new_y_s3;
	assign last_out = last_s3;
	assign clipped  = clipped_s3;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: vertex_affine_transform regression
// Drives vertices through every transform mode under random handshake gaps
// and a long receiver hold-off. Each accepted vertex is run through a local
// fixed-point transform with its own sine table, and each output transaction
// is compared field by field, in order, with the predicted vertex.
// ----------------------------------------------------------------------------
module testbench;
	import vat_pkg::*;

	localparam int CW    = 16;
	localparam int CFG_W = 16;
	localparam int FRAC  = 16;
	// pi in Q60
	localparam bit [63:0] HALF_TURN_Q60 = 64'h3243F6A8885A308D;

	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic                 lst;
	} vertex_in_t;

	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic                 lst;
		logic                 clip;
	} vertex_out_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [1:0]           cfg_index = 2'd0;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic signed [CW-1:0] coord_x   = '0;
	logic signed [CW-1:0] coord_y   = '0;
	logic                 is_last   = 1'b0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic signed [CW-1:0] new_x;
	logic signed [CW-1:0] new_y;
	logic                 last_out;
	logic                 clipped;

	// local copy of the register file
	logic [2:0]           cur_mode  = 3'd0;
	logic signed [CW-1:0] cur_ax    = '0;
	logic signed [CW-1:0] cur_ay    = '0;
	logic [8:0]           cur_angle = 9'd0;

	longint      sine_table [0:90];
	vertex_in_t  pending_vertices [$];
	vertex_out_t expected_vertices [$];
	vertex_in_t  next_vertex;
	vertex_out_t result_want;
	int          vertices_queued = 0;
	int          results_seen    = 0;
	int          failures        = 0;
	int          hold_cycles     = 0;
	bit          steady          = 1'b0;

	vertex_affine_transform dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.is_last   (is_last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.new_x     (new_x),
		.new_y     (new_y),
		.last_out  (last_out),
		.clipped   (clipped)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// sin(k deg) by Q30 Taylor series, rounded half up to Q16
	function automatic longint sine_q16(input int unsigned k);
		bit [63:0] ang;
		bit [63:0] ang2;
		bit [63:0] term;
		longint    acc;
		ang  = ((HALF_TURN_Q60 / 64'd180) * 64'(k) + (64'd1 << 29)) >> 30;
		ang2 = (ang * ang + (64'd1 << 29)) >> 30;
		term = ang;
		acc  = longint'(ang);
		for (int n = 1; n <= 8; n++) begin
			term = ((term * ang2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if (n % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		return longint'((64'(acc) + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
	endfunction

	// sine of any angle from the quarter-wave table
	function automatic longint sine_of(input int unsigned a);
		int unsigned r;
		r = a % 360;
		if (r <= 90) return sine_table[r];
		if (r <= 180) return sine_table[180 - r];
		if (r <= 270) return -sine_table[r - 180];
		return -sine_table[360 - r];
	endfunction

	// clamp to the signed coordinate range, flag when it bites
	function automatic logic signed [CW-1:0] clamp(input longint v, inout logic hit);
		if (v > 32767) begin
			hit = 1'b1;
			return 16'sh7FFF;
		end
		if (v < -32768) begin
			hit = 1'b1;
			return 16'sh8000;
		end
		return CW'(v);
	endfunction

	// expected output for one vertex under the current registers
	function automatic vertex_out_t transform_vertex(input vertex_in_t v);
		longint      px;
		longint      py;
		longint      nx;
		longint      ny;
		longint      s;
		longint      c;
		vertex_out_t r;
		px = v.x;
		py = v.y;
		nx = px;
		ny = py;
		r.clip = 1'b0;
		case (cur_mode)
			MODE_TRANSLATE: begin
				nx = px + longint'(cur_ax);
				ny = py + longint'(cur_ay);
			end
			MODE_SCALE: begin
				nx = px * longint'(cur_ax);
				ny = py * longint'(cur_ay);
			end
			MODE_ROTATE: begin
				s  = sine_of(cur_angle);
				c  = sine_of(cur_angle + 90);
				nx = (px * c - py * s) / (64'sd1 << FRAC);
				ny = (px * s + py * c) / (64'sd1 << FRAC);
			end
			MODE_SHEAR: begin
				nx = px + longint'(cur_ax) * py;
				ny = py + longint'(cur_ay) * px;
			end
			MODE_REFLECT: begin
				nx = -py;
				ny = -px;
			end
			default: begin
			end
		endcase
		r.x   = clamp(nx, r.clip);
		r.y   = clamp(ny, r.clip);
		r.lst = v.lst;
		return r;
	endfunction

	// input driver: predicts on each accepted transaction, then offers the next
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			coord_x  <= '0;
			coord_y  <= '0;
			is_last  <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				next_vertex.x   = coord_x;
				next_vertex.y   = coord_y;
				next_vertex.lst = is_last;
				expected_vertices.push_back(transform_vertex(next_vertex));
			end
			if (!in_valid || in_ready) begin
				if (pending_vertices.size() > 0 && (steady || $urandom_range(99) >= 33)) begin
					next_vertex = pending_vertices.pop_front();
					in_valid <= 1'b1;
					coord_x  <= next_vertex.x;
					coord_y  <= next_vertex.y;
					is_last  <= next_vertex.lst;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver hold-off countdown
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
		end
	end

	// output monitor and checker
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_vertices.size() == 0) begin
					$error("result with no vertex outstanding: new_x %0d new_y %0d",
						new_x, new_y);
					failures++;
				end else begin
					result_want = expected_vertices.pop_front();
					results_seen++;
					if (new_x !== result_want.x) begin
						$error("new_x: expected %0d, got %0d", result_want.x, new_x);
						failures++;
					end
					if (new_y !== result_want.y) begin
						$error("new_y: expected %0d, got %0d", result_want.y, new_y);
						failures++;
					end
					if (last_out !== result_want.lst) begin
						$error("last_out: expected %0b, got %0b", result_want.lst, last_out);
						failures++;
					end
					if (clipped !== result_want.clip) begin
						$error("clipped: expected %0b, got %0b", result_want.clip, clipped);
						failures++;
					end
				end
			end
			out_ready <= (hold_cycles == 0) && (steady || $urandom_range(99) >= 33);
		end
	end

	// write all four registers while the pipeline is empty
	task automatic configure(input logic [2:0] mode_val, input logic signed [CW-1:0] ax,
		input logic signed [CW-1:0] ay, input logic [8:0] ang);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MODE;
		cfg_wdata <= CFG_W'(mode_val);
		@(posedge clk);
		cfg_index <= REG_AMOUNT_X;
		cfg_wdata <= ax;
		@(posedge clk);
		cfg_index <= REG_AMOUNT_Y;
		cfg_wdata <= ay;
		@(posedge clk);
		cfg_index <= REG_ANGLE;
		cfg_wdata <= CFG_W'(ang);
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_mode  = mode_val;
		cur_ax    = ax;
		cur_ay    = ay;
		cur_angle = ang;
		@(posedge clk);
	endtask

	task automatic push_vertex(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
		input logic lst);
		vertex_in_t v;
		v.x   = x;
		v.y   = y;
		v.lst = lst;
		pending_vertices.push_back(v);
		vertices_queued++;
	endtask

	// wait until every queued vertex has come back, then let the pipe settle
	task automatic drain();
		while (results_seen < vertices_queued) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	function automatic logic signed [CW-1:0] pick_coord();
		case ($urandom_range(5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return CW'(int'($urandom_range(128)) - 64);
			3: return CW'(int'($urandom_range(4096)) - 2048);
			default: return CW'($urandom);
		endcase
	endfunction

	// scale and shear factors mostly small so results do not always clip
	function automatic logic signed [CW-1:0] pick_amount(input logic [2:0] m);
		if ((m == MODE_SCALE || m == MODE_SHEAR) && $urandom_range(3) != 0) begin
			return CW'(int'($urandom_range(16)) - 8);
		end
		case ($urandom_range(4))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			default: return CW'($urandom);
		endcase
	endfunction

	// stimulus
	initial begin
		int unsigned          angles [8];
		logic [2:0]           mode_val;
		logic signed [CW-1:0] ax;
		logic signed [CW-1:0] ay;
		int                   n;

		angles = '{0, 45, 90, 180, 270, 359, 400, 511};
		for (int k = 0; k <= 90; k++) begin
			sine_table[k] = sine_q16(k);
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: translate by zero
		push_vertex(16'sd0, 16'sd0, 1'b0);
		push_vertex(16'sh7FFF, 16'sh8000, 1'b1);
		push_vertex(-16'sd1, 16'sd1, 1'b0);
		drain();

		// translate with extreme offsets
		configure(MODE_TRANSLATE, 16'sh7FFF, 16'sh8000, 9'd0);
		push_vertex(16'sd1, -16'sd1, 1'b0);
		push_vertex(16'sh8000, 16'sh7FFF, 1'b1);
		drain();

		// scale with extreme factors
		configure(MODE_SCALE, 16'sh8000, 16'sh7FFF, 9'd0);
		push_vertex(-16'sd1, 16'sd1, 1'b0);
		push_vertex(16'sd2, -16'sd2, 1'b1);
		push_vertex(16'sd0, 16'sd0, 1'b0);
		drain();

		// rotate through quadrant edges and angles past a full turn
		foreach (angles[i]) begin
			configure(MODE_ROTATE, 16'sd0, 16'sd0, 9'(angles[i]));
			push_vertex(16'sh7FFF, 16'sh8000, 1'(i));
			drain();
		end

		// shear
		configure(MODE_SHEAR, 16'sh8000, 16'sh7FFF, 9'd0);
		push_vertex(16'sd100, -16'sd3, 1'b0);
		push_vertex(16'sh8000, 16'sh8000, 1'b1);
		drain();

		// reflect, including negation of the most negative value
		configure(MODE_REFLECT, 16'sd0, 16'sd0, 9'd0);
		push_vertex(16'sh8000, 16'sh7FFF, 1'b0);
		push_vertex(16'sd5, -16'sd7, 1'b1);
		push_vertex(16'sh7FFF, 16'sh8000, 1'b0);
		drain();

		// unused mode codes pass the vertex through
		for (int m = 5; m <= 7; m++) begin
			configure(3'(m), 16'sd3, -16'sd3, 9'd10);
			push_vertex(16'sh8000, 16'sd1234, 1'(m));
			drain();
		end

		// random phases, one of them with a long receiver hold-off
		for (int p = 0; p < 12; p++) begin
			mode_val = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5))
				: 3'($urandom_range(4));
			ax = pick_amount(mode_val);
			ay = pick_amount(mode_val);
			configure(mode_val, ax, ay, 9'($urandom_range(511)));
			if (p == 5) begin
				steady      <= 1'b1;
				hold_cycles <= 150;
			end
			n = $urandom_range(30, 50);
			repeat (n) push_vertex(pick_coord(), pick_coord(), 1'($urandom_range(1)));
			drain();
			steady <= 1'b0;
		end

		if (expected_vertices.size() != 0) begin
			$error("%0d expected vertices never arrived", expected_vertices.size());
			failures++;
		end
		if (failures == 0) begin
			$display("vertex_affine_transform regression: pass");
		end else begin
			$display("vertex_affine_transform regression: fail");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("vertex_affine_transform regression: fail");
		$finish;
	end

endmodule
